>>> design/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// shared constants, control structs and the count scaling for the sound
// generator
// ----------------------------------------------------------------------------
package psg_pkg;

  // count scaling: floor(v * 55125 / 279652) for any 10-bit v, done as
  // floor(v * ScaleMul / 2^ScaleShift), exact over the whole 10-bit range
  localparam int unsigned ScaleNum   = 55125;
  localparam int unsigned ScaleDen   = 279652;
  localparam int unsigned ScaleShift = 29;
  localparam int unsigned MulWidth   = 27;
  localparam logic [MulWidth-1:0] ScaleMul = 27'd105827990;

  localparam int unsigned PeriodWidth = 10;
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned ProdWidth   = PeriodWidth + MulWidth;

  // fixed noise reloads, scaled at elaboration
  localparam logic [CountWidth-1:0] NoiseBase0 = CountWidth'((218 * ScaleNum) / ScaleDen);
  localparam logic [CountWidth-1:0] NoiseBase1 = CountWidth'((109 * ScaleNum) / ScaleDen);
  localparam logic [CountWidth-1:0] NoiseBase2 = CountWidth'((54 * ScaleNum) / ScaleDen);

  // register field codes
  localparam logic [1:0] ChNoise      = 2'd3;
  localparam logic [1:0] RateFromTone = 2'd3;
  localparam logic [1:0] Rate0        = 2'd0;
  localparam logic [1:0] Rate1        = 2'd1;
  localparam logic [1:0] Rate2        = 2'd2;

  localparam logic [15:0] LfsrSeed    = 16'h8000;
  localparam int unsigned NumTones    = 3;

  // per-channel control for one beat
  typedef struct packed {
    logic step;
    logic atten_we;
    logic per_lo_we;
    logic per_hi_we;
  } psg_tone_ctl_t;

  typedef struct packed {
    logic step;
    logic atten_we;
    logic restart;
  } psg_noise_ctl_t;

  // square-wave flip: toward the opposite sign at (15 - atten) * 4
  function automatic logic signed [6:0] psg_flip(input logic signed [6:0] level,
                                                  input logic [3:0] atten);
    logic [5:0] mag;
    logic signed [6:0] pos;
    mag = {4'hF - atten, 2'b00};
    pos = $signed({1'b0, mag});
    return (!level[6] && (level != 7'sd0)) ? -pos : pos;
  endfunction

endpackage

>>> design/psg_in_if.sv
// ----------------------------------------------------------------------------
// psg_in_if
// request channel: port write or sample request
// ----------------------------------------------------------------------------
interface psg_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data;

  modport source (output valid, output op, output data, input ready);
  modport sink (input valid, input op, input data, output ready);
endinterface

>>> design/psg_out_if.sv
// ----------------------------------------------------------------------------
// psg_out_if
// result channel: mixed sample and masked port byte
// ----------------------------------------------------------------------------
interface psg_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] sample;
  logic        [7:0] port_echo;

  modport source (output valid, output sample, output port_echo, input ready);
  modport sink (input valid, input sample, input port_echo, output ready);
endinterface

>>> design/psg_scale.sv
// ----------------------------------------------------------------------------
// psg_scale
// constant multiply that turns a 10-bit period into a sample count
// ----------------------------------------------------------------------------
module psg_scale
  import psg_pkg::*;
(
  input  logic [PeriodWidth-1:0] period,
  output logic [CountWidth-1:0]  count
);

  logic [ProdWidth-1:0] prod;

  assign prod  = ProdWidth'(period) * ProdWidth'(ScaleMul);
  assign count = prod[ScaleShift +: CountWidth];

endmodule

>>> design/psg_tone_ch.sv
// ----------------------------------------------------------------------------
// psg_tone_ch
// one square-wave tone channel: period, attenuation, counter and level
// ----------------------------------------------------------------------------
module psg_tone_ch
  import psg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  psg_tone_ctl_t          ctl,
  input  logic [5:0]             wdata,
  output logic signed [6:0]      level_nxt,
  output logic [CountWidth-1:0]  scaled
);

  logic [PeriodWidth-1:0] period_r, period_nxt;
  logic [3:0]             atten_r, atten_nxt;
  logic [6:0]             count_r, count_nxt;
  logic signed [6:0]      level_r;

  psg_scale u_scale (
    .period (period_r),
    .count  (scaled)
  );

  always_comb begin
    period_nxt = period_r;
    atten_nxt  = atten_r;
    count_nxt  = count_r;
    level_nxt  = level_r;
    if (ctl.atten_we) begin
      atten_nxt = wdata[3:0];
    end
    if (ctl.per_lo_we) begin
      period_nxt = {period_r[9:4], wdata[3:0]};
    end
    if (ctl.per_hi_we) begin
      period_nxt = {wdata, period_r[3:0]};
    end
    if (ctl.step) begin
      if (count_r == 7'd0) begin
        // half period, always below 128
        count_nxt = scaled[CountWidth-1:1];
        level_nxt = psg_flip(level_r, atten_r);
      end else begin
        count_nxt = count_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      atten_r  <= '0;
      count_r  <= '0;
      level_r  <= '0;
    end else begin
      period_r <= period_nxt;
      atten_r  <= atten_nxt;
      count_r  <= count_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

>>> design/psg_noise_ch.sv
// ----------------------------------------------------------------------------
// psg_noise_ch
// noise channel: rate select, 16-bit shift register, counter and level
// ----------------------------------------------------------------------------
module psg_noise_ch
  import psg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  psg_noise_ctl_t        ctl,
  input  logic [5:0]            wdata,
  input  logic [CountWidth-1:0] tone2_scaled,
  output logic signed [6:0]     level_nxt
);

  logic [3:0]            atten_r, atten_nxt;
  logic [CountWidth-1:0] count_r, count_nxt;
  logic                  halted_r, halted_nxt;
  logic [1:0]            rate_r, rate_nxt;
  logic                  white_r, white_nxt;
  logic [15:0]           lfsr_r, lfsr_nxt;
  logic signed [6:0]     level_r;
  logic [CountWidth-1:0] reload;
  logic                  tap;

  always_comb begin
    unique case (rate_r)
      Rate0:        reload = NoiseBase0;
      Rate1:        reload = NoiseBase1;
      Rate2:        reload = NoiseBase2;
      RateFromTone: reload = tone2_scaled;
      default:      reload = NoiseBase0;
    endcase
  end

  // white taps bits 0 and 3, periodic taps bit 0
  assign tap = white_r ? (lfsr_r[0] ^ lfsr_r[3]) : lfsr_r[0];

  always_comb begin
    atten_nxt  = atten_r;
    count_nxt  = count_r;
    halted_nxt = halted_r;
    rate_nxt   = rate_r;
    white_nxt  = white_r;
    lfsr_nxt   = lfsr_r;
    level_nxt  = level_r;
    if (ctl.atten_we) begin
      atten_nxt = wdata[3:0];
    end
    if (ctl.restart) begin
      count_nxt  = '0;
      halted_nxt = 1'b0;
      white_nxt  = wdata[2];
      rate_nxt   = wdata[1:0];
      lfsr_nxt   = LfsrSeed;
    end
    if (ctl.step && !halted_r) begin
      if (count_r == '0) begin
        lfsr_nxt = {tap, lfsr_r[15:1]};
        if (lfsr_r[1]) begin
          level_nxt = psg_flip(level_r, atten_r);
        end
        // zero reload parks the generator until the next restart
        if (reload == '0) begin
          halted_nxt = 1'b1;
        end else begin
          count_nxt = reload - CountWidth'(1);
        end
      end else begin
        count_nxt = count_r - CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atten_r  <= '0;
      count_r  <= '0;
      halted_r <= 1'b0;
      rate_r   <= '0;
      white_r  <= 1'b0;
      lfsr_r   <= '0;
      level_r  <= '0;
    end else begin
      atten_r  <= atten_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
      rate_r   <= rate_nxt;
      white_r  <= white_nxt;
      lfsr_r   <= lfsr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

>>> design/psg_tone_noise_generator.sv
// ----------------------------------------------------------------------------
// psg_tone_noise_generator
// three square-wave tones plus one noise channel behind a latch/data byte
// port, one mixed signed sample per sample request
// ----------------------------------------------------------------------------
//
//   channel   direction  beat payload                  handshake
//   in_if     in         op, data[7:0]                 valid / ready
//   out_if    out        sample[7:0] s, port_echo[7:0]  valid / ready
//
// one beat per cycle sustained while out_if.ready stays high; a result is
// valid once its request beat has passed the request register and then
// the result register
// the per-sample work (three constant-multiply count scalers, counter and
// level updates, four-way mix) sits between those two registers
// reset (synchronous, rst_n low) clears every channel, the latch and both
// pipeline valids
// out_if.ready low holds the result register; the request register still
// takes one more beat, then in_if.ready drops
//
module psg_tone_noise_generator
  import psg_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  psg_in_if.sink        in_if,
  psg_out_if.source     out_if
);

  // request stage
  logic       req_v_r;
  logic       op_r;
  logic [7:0] data_r;

  // result stage
  logic              out_v_r;
  logic signed [7:0] sample_r, sample_nxt;
  logic [7:0]        echo_r, echo_nxt;

  // latch state of the byte port
  logic [1:0] lat_ch_r, lat_ch_nxt;
  logic       lat_vol_r, lat_vol_nxt;

  logic       in_fire;
  logic       advance;
  logic       fire;
  logic       is_latch;
  logic       is_write;
  logic [5:0] wval;

  psg_tone_ctl_t          tone_ctl [NumTones];
  logic signed [6:0]      tone_lvl [NumTones];
  logic [CountWidth-1:0]  tone_scaled [NumTones];
  psg_noise_ctl_t         noise_ctl;
  logic signed [6:0]      noise_lvl;

  // handshake: result register frees up as the sink takes it
  assign advance     = !out_v_r || out_if.ready;
  assign in_if.ready = !req_v_r || advance;
  assign in_fire     = in_if.valid && in_if.ready;
  assign fire        = req_v_r && advance;

  // byte port decode: a latch byte sets channel and type and carries 4 bits,
  // a data byte carries 6 bits for the latched register
  assign is_write    = fire && !op_r;
  assign is_latch    = data_r[7];
  assign lat_ch_nxt  = is_latch ? data_r[6:5] : lat_ch_r;
  assign lat_vol_nxt = is_latch ? data_r[4] : lat_vol_r;
  assign wval        = is_latch ? {2'b00, data_r[3:0]} : data_r[5:0];

  genvar gi;
  generate
    for (gi = 0; gi < NumTones; gi++) begin : g_tone
      logic sel;
      assign sel = is_write && (lat_ch_nxt == 2'(gi));
      assign tone_ctl[gi].step      = fire && op_r;
      assign tone_ctl[gi].atten_we  = sel && lat_vol_nxt;
      assign tone_ctl[gi].per_lo_we = sel && !lat_vol_nxt && is_latch;
      assign tone_ctl[gi].per_hi_we = sel && !lat_vol_nxt && !is_latch;

      psg_tone_ch u_tone (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tone_ctl[gi]),
        .wdata     (wval),
        .level_nxt (tone_lvl[gi]),
        .scaled    (tone_scaled[gi])
      );
    end
  endgenerate

  assign noise_ctl.step     = fire && op_r;
  assign noise_ctl.atten_we = is_write && (lat_ch_nxt == ChNoise) && lat_vol_nxt;
  assign noise_ctl.restart  = is_write && (lat_ch_nxt == ChNoise) && !lat_vol_nxt;

  // rate 3 takes its reload from tone 2's period
  psg_noise_ch u_noise (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (noise_ctl),
    .wdata        (wval),
    .tone2_scaled (tone_scaled[NumTones-1]),
    .level_nxt    (noise_lvl)
  );

  // mix: four sign-extended levels, wrapping modulo 256
  always_comb begin
    if (op_r) begin
      sample_nxt = {tone_lvl[0][6], tone_lvl[0]} + {tone_lvl[1][6], tone_lvl[1]}
                 + {tone_lvl[2][6], tone_lvl[2]} + {noise_lvl[6], noise_lvl};
      echo_nxt   = '0;
    end else begin
      sample_nxt = '0;
      echo_nxt   = {2'b00, wval};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
      lat_ch_r  <= '0;
      lat_vol_r <= 1'b0;
    end else begin
      if (in_fire) begin
        req_v_r <= 1'b1;
      end else if (fire) begin
        req_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
      if (is_write) begin
        lat_ch_r  <= lat_ch_nxt;
        lat_vol_r <= lat_vol_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_if.op;
      data_r <= in_if.data;
    end
    if (fire) begin
      sample_r <= sample_nxt;
      echo_r   <= echo_nxt;
    end
  end

  assign out_if.valid     = out_v_r;
  assign out_if.sample    = sample_r;
  assign out_if.port_echo = echo_r;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives port writes and sample requests into the sound generator through
// its valid/ready channels, tracks every tone, noise and latch register in
// a cycle-free software copy, and compares each result beat field by field
// ----------------------------------------------------------------------------
module testbench;
  import psg_pkg::*;

  // request opcodes and register type bit of a latch byte
  localparam logic OpWrite    = 1'b0;
  localparam logic OpSample   = 1'b1;
  localparam logic TypePeriod = 1'b0;
  localparam logic TypeVolume = 1'b1;

  // tone channel indexes; the noise channel index comes from the package
  localparam logic [1:0] ChTone0 = 2'd0;
  localparam logic [1:0] ChTone1 = 2'd1;
  localparam logic [1:0] ChTone2 = 2'd2;

  // count scaling: floor(v * TickNum / TickDen)
  localparam int unsigned TickNum = 55125;
  localparam int unsigned TickDen = 279652;

  // fixed noise divider inputs for rates 0..2
  localparam int unsigned NoiseDiv0 = 218;
  localparam int unsigned NoiseDiv1 = 109;
  localparam int unsigned NoiseDiv2 = 54;

  localparam int CycleLimit  = 600000;
  localparam int SettleBeats = 4;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic signed [7:0] sample;
    logic        [7:0] port_echo;
  } mix_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  psg_in_if  in_if ();
  psg_out_if out_if ();

  psg_tone_noise_generator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // software copy of the generator state, all zero at reset
  // --------------------------------------------------------------------------
  logic        [9:0] tone_per   [3];
  logic        [3:0] tone_att   [3];
  logic        [6:0] tone_cnt   [3];
  logic signed [6:0] tone_lvl   [3];
  logic        [3:0] noise_att  = '0;
  logic        [7:0] noise_cnt  = '0;
  logic              noise_stop = 1'b0;
  logic        [1:0] noise_sel  = '0;
  logic              noise_wht  = 1'b0;
  logic       [15:0] shift_reg  = '0;
  logic signed [6:0] noise_lvl  = '0;
  logic        [1:0] latch_ch   = '0;
  logic              latch_vol  = 1'b0;

  initial begin
    for (int i = 0; i < 3; i++) begin
      tone_per[i] = '0;
      tone_att[i] = '0;
      tone_cnt[i] = '0;
      tone_lvl[i] = '0;
    end
  end

  mix_result_t sample_echo_due[$];

  int mismatches     = 0;
  int results_seen   = 0;
  int beats_sent     = 0;
  int source_gap_pct = 0;
  int sink_stall_pct = 0;
  int stall_left     = 0;
  int cycles         = 0;

  // scaled count for a 10-bit value, halved for a tone, whole for a noise reload
  function automatic int unsigned tick_count(input logic [9:0] v);
    return (32'(v) * TickNum) / TickDen;
  endfunction

  // square-wave swing: positive goes negative, zero or negative goes positive
  function automatic logic signed [6:0] swing_level(input logic signed [6:0] level,
                                                    input logic [3:0] att);
    int mag;
    mag = (15 - int'(att)) * 4;
    return (level > 0) ? 7'(-mag) : 7'(mag);
  endfunction

  // a port byte: latch byte (bit 7 set) or data byte for the latched register
  function automatic logic [7:0] apply_port_byte(input logic [7:0] b);
    logic [7:0] v;
    logic       upper;
    if (b[7]) begin
      latch_ch  = b[6:5];
      latch_vol = b[4];
      v         = {4'h0, b[3:0]};
      upper     = 1'b0;
    end else begin
      v     = {2'b00, b[5:0]};
      upper = 1'b1;
    end
    if (latch_ch != ChNoise) begin
      if (latch_vol) begin
        tone_att[latch_ch] = v[3:0];
      end else if (!upper) begin
        tone_per[latch_ch][3:0] = v[3:0];
      end else begin
        tone_per[latch_ch][9:4] = v[5:0];
      end
    end else if (latch_vol) begin
      noise_att = v[3:0];
    end else begin
      // any period write to the noise channel restarts it
      noise_cnt  = '0;
      noise_stop = 1'b0;
      noise_wht  = v[2];
      noise_sel  = v[1:0];
      shift_reg  = LfsrSeed;
    end
    return v;
  endfunction

  // step every counter once and return the wrapped sum of the four levels
  function automatic logic signed [7:0] mix_next_sample();
    int          acc;
    int unsigned reload;
    logic        tap;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      if (tone_cnt[i] == '0) begin
        tone_cnt[i] = 7'(tick_count(tone_per[i]) / 2);
        tone_lvl[i] = swing_level(tone_lvl[i], tone_att[i]);
      end else begin
        tone_cnt[i] = tone_cnt[i] - 7'd1;
      end
      acc += int'(tone_lvl[i]);
    end
    if (!noise_stop) begin
      if (noise_cnt == '0) begin
        case (noise_sel)
          Rate0:   reload = tick_count(10'(NoiseDiv0));
          Rate1:   reload = tick_count(10'(NoiseDiv1));
          Rate2:   reload = tick_count(10'(NoiseDiv2));
          default: reload = tick_count(tone_per[2]);
        endcase
        tap       = noise_wht ? (shift_reg[0] ^ shift_reg[3]) : shift_reg[0];
        shift_reg = {tap, shift_reg[15:1]};
        if (shift_reg[0]) begin
          noise_lvl = swing_level(noise_lvl, noise_att);
        end
        // a zero reload parks the noise channel until its next period write
        if (reload == 0) begin
          noise_stop = 1'b1;
        end else begin
          noise_cnt = 8'(reload - 1);
        end
      end else begin
        noise_cnt = noise_cnt - 8'd1;
      end
    end
    acc += int'(noise_lvl);
    return 8'(acc);
  endfunction

  // --------------------------------------------------------------------------
  // beat monitor: requests feed the prediction, results are checked in order
  // --------------------------------------------------------------------------
  function automatic void flag_mismatch(input string field, input int idx,
                                        input int want_v, input int got_v);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("result %0d: %s expected %0d got %0d", idx, field, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    mix_result_t want;
    mix_result_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        if (in_if.op == OpSample) begin
          want.sample    = mix_next_sample();
          want.port_echo = '0;
        end else begin
          want.sample    = '0;
          want.port_echo = apply_port_byte(in_if.data);
        end
        sample_echo_due.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        got.sample    = out_if.sample;
        got.port_echo = out_if.port_echo;
        if (sample_echo_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("result %0d: unexpected beat, sample %0d port_echo %0d",
                     results_seen, got.sample, got.port_echo);
          end
        end else begin
          want = sample_echo_due.pop_front();
          if (got.sample !== want.sample) begin
            flag_mismatch("sample", results_seen, want.sample, got.sample);
          end
          if (got.port_echo !== want.port_echo) begin
            flag_mismatch("port_echo", results_seen, want.port_echo, got.port_echo);
          end
        end
        results_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // idling: mostly short gaps, now and then a long one
  // --------------------------------------------------------------------------
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) begin
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      return $urandom_range(40, 12);
    end
    return $urandom_range(3, 1);
  endfunction

  // result side back-pressure, one assignment per falling edge
  always @(negedge clk) begin
    int gap;
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      gap = pick_gap(sink_stall_pct);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        stall_left = gap - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // request side: called and returning at a falling edge; valid stays high
  // across back-to-back beats
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic op, input logic [7:0] b);
    int gap;
    gap = pick_gap(source_gap_pct);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.data  <= b;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic write_byte(input logic [7:0] b);
    send_beat(OpWrite, b);
  endtask

  task automatic take_sample(input logic [7:0] junk);
    send_beat(OpSample, junk);
  endtask

  // drop valid and hold off until every result beat is back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sample_echo_due.size() != 0) @(negedge clk);
    repeat (SettleBeats) @(negedge clk);
  endtask

  function automatic logic [7:0] latch_byte(input logic [1:0] ch, input logic kind,
                                            input logic [3:0] val);
    return {1'b1, ch, kind, val};
  endfunction

  // bit 6 of a data byte is a don't-care
  function automatic logic [7:0] data_byte(input logic [5:0] val, input logic spare);
    return {1'b0, spare, val};
  endfunction

  // noise control nibble: spare bit, white, rate
  function automatic logic [3:0] noise_ctl(input logic spare, input logic white,
                                           input logic [1:0] rate);
    return {spare, white, rate};
  endfunction

  // --------------------------------------------------------------------------
  // directed tests
  // --------------------------------------------------------------------------

  // zero periods at full volume: every tone flips on each sample
  task automatic test_after_reset();
    take_sample(8'h00);
    take_sample(8'hFF);
    wait_drained();
  endtask

  // period halves on both byte forms, volume from a latch and from a data
  // byte with all six bits set (only four survive)
  task automatic test_tone_registers();
    write_byte(latch_byte(ChTone0, TypePeriod, 4'h0));
    write_byte(data_byte(6'h3F, 1'b0));
    write_byte(latch_byte(ChTone0, TypeVolume, 4'h0));
    write_byte(latch_byte(ChTone1, TypeVolume, 4'hF));
    write_byte(data_byte(6'h3F, 1'b1));
    write_byte(latch_byte(ChTone1, TypePeriod, 4'hF));
    // tone 2 period of 5 scales to a zero count
    write_byte(latch_byte(ChTone2, TypePeriod, 4'h5));
    write_byte(data_byte(6'h00, 1'b1));
    wait_drained();
  endtask

  // noise driven from tone 2 with a zero reload halts, a new write restarts
  task automatic test_noise_halt();
    write_byte(latch_byte(ChNoise, TypeVolume, 4'h0));
    write_byte(latch_byte(ChNoise, TypePeriod, noise_ctl(1'b0, 1'b0, RateFromTone)));
    take_sample(8'h55);
    take_sample(8'hAA);
    take_sample(8'hFF);
    write_byte(latch_byte(ChNoise, TypePeriod, noise_ctl(1'b1, 1'b1, RateFromTone)));
    take_sample(8'h00);
    wait_drained();
  endtask

  // fixed rates, restart through a data byte, noise volume through both forms
  task automatic test_noise_rates();
    write_byte(data_byte({2'b00, noise_ctl(1'b0, 1'b1, Rate0)}, 1'b0));
    take_sample(8'hFF);
    write_byte(latch_byte(ChNoise, TypePeriod, noise_ctl(1'b0, 1'b1, Rate2)));
    take_sample(8'h01);
    write_byte(latch_byte(ChNoise, TypePeriod, noise_ctl(1'b0, 1'b1, Rate1)));
    take_sample(8'h80);
    write_byte(latch_byte(ChNoise, TypeVolume, 4'hF));
    take_sample(8'h7F);
    write_byte(data_byte(6'h00, 1'b0));
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // random traffic: a register update phrase followed by a run of samples,
  // with some stray bytes mixed in
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int beats, input int gap_pct,
                                     input int stall_pct);
    int         goal;
    int         kind;
    int         run;
    logic [1:0] ch;
    source_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    goal = beats_sent + beats;
    while (beats_sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        // tone period, usually both halves
        ch = 2'($urandom_range(2));
        write_byte(latch_byte(ch, TypePeriod, 4'($urandom)));
        if ($urandom_range(3) != 0) begin
          write_byte(data_byte(6'($urandom), 1'($urandom)));
        end
      end else if (kind < 45) begin
        // volume on any channel, sometimes rewritten by a data byte
        ch = 2'($urandom);
        write_byte(latch_byte(ch, TypeVolume, 4'($urandom)));
        if ($urandom_range(2) == 0) begin
          write_byte(data_byte(6'($urandom), 1'($urandom)));
        end
      end else if (kind < 58) begin
        // noise control, latch or data form
        write_byte(latch_byte(ChNoise, TypePeriod, 4'($urandom)));
        if ($urandom_range(3) == 0) begin
          write_byte(data_byte(6'($urandom), 1'($urandom)));
        end
      end else if (kind < 66) begin
        // short tone 2 period feeding the noise divider, often a zero reload
        write_byte(latch_byte(ChTone2, TypePeriod, 4'($urandom)));
        write_byte(data_byte(($urandom_range(3) == 0) ? 6'($urandom) : 6'h00,
                             1'($urandom)));
        write_byte(latch_byte(ChNoise, TypePeriod,
                              noise_ctl(1'($urandom), 1'($urandom), RateFromTone)));
      end else if (kind < 76) begin
        // stray byte of any value
        write_byte(8'($urandom));
      end
      run = ($urandom_range(9) == 0) ? $urandom_range(120, 30) : $urandom_range(12, 1);
      repeat (run) take_sample(8'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.op     = OpWrite;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_after_reset();
    test_tone_registers();
    test_noise_halt();
    test_noise_rates();
    test_random_traffic(600, 0, 0);
    test_random_traffic(600, 20, 25);
    test_random_traffic(620, 55, 50);

    repeat (SettleBeats) @(negedge clk);
    if (mismatches == 0 && sample_echo_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
